>>> rtl/ictf_pkg.sv
package ictf_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int ANGLE_W    = 26;
   localparam int TEMP_W     = 15;
   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 96;

   // divider: divisor width and quotient bits retired per cycle
   localparam int DIV_W     = 24;
   localparam int DIV_STEPS = 4;

   typedef struct packed {
      logic [10:0] k1;
      logic [8:0]  k2;
   } ictf_coef_type;

   // k1 = 1.755, k2 = 0.0285 on x; k1 = 1.75, k2 = 0.0286 on y and z
   // k1 held in thousandths, k2 in ten-thousandths
   localparam ictf_coef_type COEF_X  = '{k1: 11'd1755, k2: 9'd285};
   localparam ictf_coef_type COEF_YZ = '{k1: 11'd1750, k2: 9'd286};

   typedef struct packed {
      logic [SAMPLE_W-1:0] acc;
      logic [SAMPLE_W-1:0] gyro;
      logic [SAMPLE_W-1:0] acc_off;
      logic [SAMPLE_W-1:0] gyro_off;
   } ictf_axis_type;

   typedef struct packed {
      logic               done;
      logic [ANGLE_W-1:0] angle;
   } ictf_lane_stat_type;

endpackage

>>> rtl/ictf_div.sv
module ictf_div #(
   parameter int QUO_W = 56
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start_i,
   input  logic [ictf_pkg::DIV_W-1:0] divisor_i,
   input  logic [QUO_W-1:0]           numer_i,
   output logic                       done_o,
   output logic [QUO_W-1:0]           quot_o
);
   import ictf_pkg::*;

   localparam int CNT   = QUO_W / DIV_STEPS;
   localparam int CNT_W = $clog2(CNT + 1);

   logic [DIV_W-1:0] rem_ff, rem_in;
   logic [DIV_W-1:0] dvs_ff, dvs_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             run_ff, run_in;
   logic             done_ff, done_in;

   logic [DIV_W-1:0] rem_stage [DIV_STEPS+1];
   logic [QUO_W-1:0] quo_stage [DIV_STEPS+1];
   logic [DIV_W:0]   trial     [DIV_STEPS];

   // restoring long division, dividend bits shift in from the top of quo
   always_comb begin
      rem_stage[0] = rem_ff;
      quo_stage[0] = quo_ff;
      for (int i = 0; i < DIV_STEPS; i++) begin
         trial[i] = {rem_stage[i], quo_stage[i][QUO_W-1]};
         if (trial[i] >= {1'b0, dvs_ff}) begin
            rem_stage[i+1] = DIV_W'(trial[i] - {1'b0, dvs_ff});
            quo_stage[i+1] = {quo_stage[i][QUO_W-2:0], 1'b1};
         end else begin
            rem_stage[i+1] = trial[i][DIV_W-1:0];
            quo_stage[i+1] = {quo_stage[i][QUO_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      done_in = 1'b0;
      if (start_i) begin
         rem_in = '0;
         dvs_in = divisor_i;
         quo_in = numer_i;
         cnt_in = CNT_W'(CNT);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = rem_stage[DIV_STEPS];
         quo_in = quo_stage[DIV_STEPS];
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         run_ff  <= run_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign done_o = done_ff;
   assign quot_o = quo_ff;

endmodule

>>> rtl/ictf_lane.sv
module ictf_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start_i,
   input  ictf_pkg::ictf_axis_type       axis_i,
   input  logic [ictf_pkg::SAMPLE_W-1:0] scale_i,
   input  ictf_pkg::ictf_coef_type       coef_i,
   output ictf_pkg::ictf_lane_stat_type  stat_o
);
   import ictf_pkg::*;

   localparam int AW    = FRAC_BITS + 17;  // accel angle
   localparam int RW    = FRAC_BITS + 14;  // gyro rate
   localparam int TW    = FRAC_BITS + 10;  // kept tilt
   localparam int DW    = FRAC_BITS + 18;  // angle minus tilt
   localparam int P1W   = FRAC_BITS + 31;
   localparam int NW    = FRAC_BITS + 41;
   localparam int SW    = FRAC_BITS + 14;  // tilt step
   localparam int NXW   = FRAC_BITS + 15;
   localparam int EXT_W = FRAC_BITS + 33;
   localparam int MAG_W = FRAC_BITS + 37;
   localparam int DIV_CNT = (MAG_W + DIV_STEPS - 1) / DIV_STEPS;
   localparam int QUO_W   = DIV_CNT * DIV_STEPS;
   localparam int OW      = (TW > ANGLE_W) ? TW : ANGLE_W;

   localparam logic [DIV_W-1:0] RATE_DIV  = 24'd164;
   localparam logic [DIV_W-1:0] RATE_HALF = 24'd82;
   localparam logic [DIV_W-1:0] STEP_DIV  = 24'd10000000;
   localparam logic [DIV_W-1:0] STEP_HALF = 24'd5000000;
   localparam logic signed [10:0] RATE_GAIN = 11'sd1000;
   localparam logic signed [4:0]  GYRO_GAIN = 5'sd10;
   localparam logic [EXT_W-1:0]   HALF_LSB  = EXT_W'(32768);
   localparam logic signed [NXW-1:0] LIM_POS = NXW'(360) << FRAC_BITS;
   localparam logic signed [NXW-1:0] LIM_NEG = -LIM_POS;

   typedef enum logic [2:0] {
      L_IDLE,
      L_SCALE,
      L_ANGLE,
      L_RATE,
      L_MIX,
      L_GAIN,
      L_STEP
   } lane_state_type;

   lane_state_type state_ff, state_in;

   logic signed [16:0]    da_ff, da_in;
   logic signed [16:0]    dg_ff, dg_in;
   logic signed [32:0]    prod_ff, prod_in;
   logic signed [20:0]    m10_ff, m10_in;
   logic signed [AW-1:0]  a_ff, a_in;
   logic signed [RW-1:0]  rate_ff, rate_in;
   logic signed [P1W-1:0] p1_ff, p1_in;
   logic                  neg_ff, neg_in;
   logic signed [TW-1:0]  tilt_ff, tilt_in;
   logic                  done_ff, done_in;

   logic [32:0]           prod_abs;
   logic [EXT_W-1:0]      ext_sum;
   logic [AW-1:0]         a_abs;
   logic signed [AW-1:0]  a_val;
   logic [19:0]           m10_abs;
   logic [QUO_W-1:0]      rate_num;
   logic signed [RW-1:0]  rate_val;
   logic signed [DW-1:0]  diff;
   logic signed [11:0]    k1s;
   logic signed [9:0]     k2s;
   logic signed [P1W-1:0] p1_val;
   logic signed [NW-1:0]  num_val;
   logic [NW-1:0]         num_abs;
   logic [QUO_W-1:0]      step_num;
   logic signed [SW-1:0]  step_val;
   logic signed [NXW-1:0] next_val;
   logic signed [NXW-1:0] sat_val;
   logic signed [OW-1:0]  tilt_wide;

   logic                  div_start;
   logic [DIV_W-1:0]      div_dvs;
   logic [QUO_W-1:0]      div_num;
   logic                  div_done;
   logic [QUO_W-1:0]      div_quot;

   // accel angle: diff * scale * 2^F / 2^16, rounded half away from zero
   assign prod_abs = prod_ff[32] ? 33'(-prod_ff) : 33'(prod_ff);
   assign ext_sum  = (EXT_W'(prod_abs) << FRAC_BITS) + HALF_LSB;
   assign a_abs    = ext_sum[EXT_W-1:16];
   assign a_val    = prod_ff[32] ? -$signed(a_abs) : $signed(a_abs);

   // gyro rate numerator: |10 * diff| * 2^F plus half of 164
   assign m10_abs  = m10_ff[20] ? 20'(-m10_ff) : 20'(m10_ff);
   assign rate_num = (QUO_W'(m10_abs) << FRAC_BITS) + QUO_W'(RATE_HALF);
   assign rate_val = m10_ff[20] ? -$signed(div_quot[RW-1:0]) : $signed(div_quot[RW-1:0]);

   assign k1s    = $signed({1'b0, coef_i.k1});
   assign k2s    = $signed({1'b0, coef_i.k2});
   assign diff   = DW'(a_ff) - DW'(tilt_ff);
   assign p1_val = P1W'(diff * k1s) + P1W'(rate_ff * RATE_GAIN);

   assign num_val  = NW'(p1_ff * k2s);
   assign num_abs  = num_val[NW-1] ? NW'(-num_val) : NW'(num_val);
   assign step_num = num_abs[QUO_W-1:0] + QUO_W'(STEP_HALF);
   assign step_val = neg_ff ? -$signed(div_quot[SW-1:0]) : $signed(div_quot[SW-1:0]);

   assign next_val = NXW'(tilt_ff) + NXW'(step_val);
   assign sat_val  = (next_val > LIM_POS) ? LIM_POS :
                     (next_val < LIM_NEG) ? LIM_NEG : next_val;

   always_comb begin
      div_start = 1'b0;
      div_dvs   = STEP_DIV;
      div_num   = step_num;
      if (state_ff == L_ANGLE) begin
         div_start = 1'b1;
         div_dvs   = RATE_DIV;
         div_num   = rate_num;
      end else if (state_ff == L_GAIN) begin
         div_start = 1'b1;
      end
   end

   ictf_div #(
      .QUO_W (QUO_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start_i   (div_start),
      .divisor_i (div_dvs),
      .numer_i   (div_num),
      .done_o    (div_done),
      .quot_o    (div_quot)
   );

   always_comb begin
      state_in = state_ff;
      da_in    = da_ff;
      dg_in    = dg_ff;
      prod_in  = prod_ff;
      m10_in   = m10_ff;
      a_in     = a_ff;
      rate_in  = rate_ff;
      p1_in    = p1_ff;
      neg_in   = neg_ff;
      tilt_in  = tilt_ff;
      done_in  = 1'b0;
      case (state_ff)
         L_IDLE: begin
            if (start_i) begin
               da_in    = {axis_i.acc[15], axis_i.acc} - {axis_i.acc_off[15], axis_i.acc_off};
               dg_in    = {axis_i.gyro[15], axis_i.gyro}
                        - {axis_i.gyro_off[15], axis_i.gyro_off};
               state_in = L_SCALE;
            end
         end
         L_SCALE: begin
            prod_in  = 33'(da_ff * $signed({1'b0, scale_i}));
            m10_in   = 21'(dg_ff * GYRO_GAIN);
            state_in = L_ANGLE;
         end
         L_ANGLE: begin
            a_in     = a_val;
            state_in = L_RATE;
         end
         L_RATE: begin
            if (div_done) begin
               rate_in  = rate_val;
               state_in = L_MIX;
            end
         end
         L_MIX: begin
            p1_in    = p1_val;
            state_in = L_GAIN;
         end
         L_GAIN: begin
            neg_in   = num_val[NW-1];
            state_in = L_STEP;
         end
         L_STEP: begin
            if (div_done) begin
               tilt_in  = TW'(sat_val);
               done_in  = 1'b1;
               state_in = L_IDLE;
            end
         end
         default: begin
            state_in = L_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= L_IDLE;
         tilt_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         tilt_ff  <= tilt_in;
         done_ff  <= done_in;
      end
      da_ff   <= da_in;
      dg_ff   <= dg_in;
      prod_ff <= prod_in;
      m10_ff  <= m10_in;
      a_ff    <= a_in;
      rate_ff <= rate_in;
      p1_ff   <= p1_in;
      neg_ff  <= neg_in;
   end

   assign tilt_wide    = OW'(tilt_ff);
   assign stat_o.done  = done_ff;
   assign stat_o.angle = tilt_wide[ANGLE_W-1:0];

endmodule

>>> rtl/ictf_merge.sv
module ictf_merge (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start_i,
   input  logic [ictf_pkg::SAMPLE_W-1:0]   temp_raw_i,
   input  ictf_pkg::ictf_lane_stat_type    lane_x_i,
   input  ictf_pkg::ictf_lane_stat_type    lane_y_i,
   input  ictf_pkg::ictf_lane_stat_type    lane_z_i,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [ictf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                            load_o
);
   import ictf_pkg::*;

   // floor(x / 17) == (x * ceil(2^26 / 17)) >> 26 for x below 2^18
   localparam logic [21:0]        TEMP_RECIP = 22'd3947581;
   localparam logic [17:0]        TEMP_HALF  = 18'd8;
   localparam logic [TEMP_W-1:0]  TEMP_BIAS  = 15'd3625;
   localparam logic signed [18:0] TEMP_GAIN  = 19'sd5;

   logic signed [18:0]      t5;
   logic [17:0]             t_abs;
   logic [17:0]             t_mag_ff, t_mag_in;
   logic                    t_neg_ff, t_neg_in;
   logic [39:0]             t_prod_ff, t_prod_in;
   logic [TEMP_W-1:0]       t_quo;
   logic [TEMP_W-1:0]       temp_ff, temp_in;
   logic                    pending_ff, pending_in;
   logic                    valid_ff, valid_in;
   logic [RSP_DATA_W-1:0]   data_ff, data_in;
   logic                    lanes_done;
   logic                    result_ready;
   logic                    load;

   assign t5    = 19'($signed(temp_raw_i) * TEMP_GAIN);
   assign t_abs = t5[18] ? 18'(-t5) : 18'(t5);
   assign t_quo = {1'b0, t_prod_ff[39:26]};

   // temperature settles through the t_mag, t_prod and temp registers, long before the lanes finish
   always_comb begin
      t_mag_in  = t_mag_ff;
      t_neg_in  = t_neg_ff;
      if (start_i) begin
         t_mag_in = t_abs + TEMP_HALF;
         t_neg_in = t5[18];
      end
      t_prod_in = 40'(t_mag_ff * TEMP_RECIP);
      temp_in   = (t_neg_ff ? -t_quo : t_quo) + TEMP_BIAS;
   end

   assign lanes_done   = lane_x_i.done & lane_y_i.done & lane_z_i.done;
   assign result_ready = pending_ff | lanes_done;
   assign load         = result_ready & (~valid_ff | rsp_tready);

   always_comb begin
      pending_in = result_ready & ~load;
      valid_in   = valid_ff;
      data_in    = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = {3'b000, temp_ff, lane_z_i.angle, lane_y_i.angle, lane_x_i.angle};
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= 1'b0;
         valid_ff   <= 1'b0;
      end else begin
         pending_ff <= pending_in;
         valid_ff   <= valid_in;
      end
      t_mag_ff  <= t_mag_in;
      t_neg_ff  <= t_neg_in;
      t_prod_ff <= t_prod_in;
      temp_ff   <= temp_in;
      data_ff   <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign load_o     = load;

endmodule

>>> rtl/imu_complementary_tilt_filter_top.sv
// channel | dir | handshake             | payload
// req     | in  | req_tvalid/req_tready | accel x/y/z, gyro x/y/z, temp raw (16 bit each)
// rsp     | out | rsp_tvalid/rsp_tready | angle x/y/z (26 bit), temp in 0.01 C (15 bit)
// csr     | in  | csr_valid/csr_ready   | csr_index (3 bit), csr_data (16 bit)
//
// one word in flight from accept to next accept, the time being set by
// the two passes of each lane's radix-16 divider
// the result register frees the lanes, so a word is taken while the last result waits
// a stalled rsp holds the finished tilts in the lanes until the result register drains
// reset is synchronous; tilts clear to zero, offsets to zero, accel scale to 720
module imu_complementary_tilt_filter_top #(
   parameter int FRAC_BITS = 16
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, temp_raw
   input  logic [ictf_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // angle_x, angle_y, angle_z, temp_centi, 3 zero bits
   output logic [ictf_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [2:0]                      csr_index,
   input  logic [ictf_pkg::SAMPLE_W-1:0]   csr_data
);
   import ictf_pkg::*;

   typedef enum logic [2:0] {
      CSR_ACCEL_OFF_X,
      CSR_ACCEL_OFF_Y,
      CSR_ACCEL_OFF_Z,
      CSR_GYRO_OFF_X,
      CSR_GYRO_OFF_Y,
      CSR_GYRO_OFF_Z,
      CSR_ACCEL_SCALE
   } csr_reg_type;

   localparam logic [SAMPLE_W-1:0] SCALE_RESET = 16'd720;

   logic [SAMPLE_W-1:0] aoff_x_ff, aoff_x_in;
   logic [SAMPLE_W-1:0] aoff_y_ff, aoff_y_in;
   logic [SAMPLE_W-1:0] aoff_z_ff, aoff_z_in;
   logic [SAMPLE_W-1:0] goff_x_ff, goff_x_in;
   logic [SAMPLE_W-1:0] goff_y_ff, goff_y_in;
   logic [SAMPLE_W-1:0] goff_z_ff, goff_z_in;
   logic [SAMPLE_W-1:0] scale_ff, scale_in;
   logic                busy_ff, busy_in;

   logic                accept;
   logic                load;
   ictf_axis_type       axis_x, axis_y, axis_z;
   ictf_lane_stat_type  stat_x, stat_y, stat_z;

   assign csr_ready  = 1'b1;
   assign req_tready = ~busy_ff;
   assign accept     = req_tvalid & ~busy_ff;

   always_comb begin
      aoff_x_in = aoff_x_ff;
      aoff_y_in = aoff_y_ff;
      aoff_z_in = aoff_z_ff;
      goff_x_in = goff_x_ff;
      goff_y_in = goff_y_ff;
      goff_z_in = goff_z_ff;
      scale_in  = scale_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_ACCEL_OFF_X: aoff_x_in = csr_data;
            CSR_ACCEL_OFF_Y: aoff_y_in = csr_data;
            CSR_ACCEL_OFF_Z: aoff_z_in = csr_data;
            CSR_GYRO_OFF_X:  goff_x_in = csr_data;
            CSR_GYRO_OFF_Y:  goff_y_in = csr_data;
            CSR_GYRO_OFF_Z:  goff_z_in = csr_data;
            CSR_ACCEL_SCALE: scale_in  = csr_data;
            default: begin
            end
         endcase
      end
      busy_in = busy_ff;
      if (accept) begin
         busy_in = 1'b1;
      end else if (load) begin
         busy_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         aoff_x_ff <= '0;
         aoff_y_ff <= '0;
         aoff_z_ff <= '0;
         goff_x_ff <= '0;
         goff_y_ff <= '0;
         goff_z_ff <= '0;
         scale_ff  <= SCALE_RESET;
         busy_ff   <= 1'b0;
      end else begin
         aoff_x_ff <= aoff_x_in;
         aoff_y_ff <= aoff_y_in;
         aoff_z_ff <= aoff_z_in;
         goff_x_ff <= goff_x_in;
         goff_y_ff <= goff_y_in;
         goff_z_ff <= goff_z_in;
         scale_ff  <= scale_in;
         busy_ff   <= busy_in;
      end
   end

   assign axis_x = '{acc: req_tdata[15:0], gyro: req_tdata[63:48],
                     acc_off: aoff_x_ff, gyro_off: goff_x_ff};
   assign axis_y = '{acc: req_tdata[31:16], gyro: req_tdata[79:64],
                     acc_off: aoff_y_ff, gyro_off: goff_y_ff};
   assign axis_z = '{acc: req_tdata[47:32], gyro: req_tdata[95:80],
                     acc_off: aoff_z_ff, gyro_off: goff_z_ff};

   ictf_lane #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lane_x (
      .clock   (clock),
      .reset   (reset),
      .start_i (accept),
      .axis_i  (axis_x),
      .scale_i (scale_ff),
      .coef_i  (COEF_X),
      .stat_o  (stat_x)
   );

   ictf_lane #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lane_y (
      .clock   (clock),
      .reset   (reset),
      .start_i (accept),
      .axis_i  (axis_y),
      .scale_i (scale_ff),
      .coef_i  (COEF_YZ),
      .stat_o  (stat_y)
   );

   ictf_lane #(
      .FRAC_BITS (FRAC_BITS)
   ) u_lane_z (
      .clock   (clock),
      .reset   (reset),
      .start_i (accept),
      .axis_i  (axis_z),
      .scale_i (scale_ff),
      .coef_i  (COEF_YZ),
      .stat_o  (stat_z)
   );

   ictf_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .start_i    (accept),
      .temp_raw_i (req_tdata[111:96]),
      .lane_x_i   (stat_x),
      .lane_y_i   (stat_y),
      .lane_z_i   (stat_z),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .load_o     (load)
   );

endmodule

>>> test/tb_imu_complementary_tilt_filter_top.sv
`timescale 1ns / 1ps

module tb_imu_complementary_tilt_filter_top;
   import ictf_pkg::*;

   localparam int  FRAC         = 16;
   localparam int  LIMIT_CYCLES = 600000;
   localparam int  SETTLE       = 40;
   localparam int  IDLE_PCT     = 31;

   typedef enum logic [2:0] {
      REG_ACC_OFF_X,
      REG_ACC_OFF_Y,
      REG_ACC_OFF_Z,
      REG_GYRO_OFF_X,
      REG_GYRO_OFF_Y,
      REG_GYRO_OFF_Z,
      REG_ACC_SCALE,
      REG_SPARE
   } csr_reg_e;

   // first member is the most significant, so accel_x lands in the low bits
   typedef struct packed {
      logic [15:0] temp_raw;
      logic [15:0] gyro_z;
      logic [15:0] gyro_y;
      logic [15:0] gyro_x;
      logic [15:0] accel_z;
      logic [15:0] accel_y;
      logic [15:0] accel_x;
   } sample_t;

   typedef struct packed {
      logic [2:0]         pad;
      logic [TEMP_W-1:0]  temp_centi;
      logic [ANGLE_W-1:0] angle_z;
      logic [ANGLE_W-1:0] angle_y;
      logic [ANGLE_W-1:0] angle_x;
   } tilt_word_t;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [2:0]            csr_index  = '0;
   logic [SAMPLE_W-1:0]   csr_data   = '0;
   logic                  steady     = 1'b0;

   sample_t    sample_q[$];
   tilt_word_t tilt_due_q[$];

   // predictor copy of the block's registers and tilt state
   longint acc_off[3];
   longint gyro_off[3];
   longint acc_scale;
   longint tilt[3];

   int cycles     = 0;
   int errors     = 0;
   int n_sent     = 0;
   int n_checked  = 0;
   int n_csr      = 0;

   imu_complementary_tilt_filter_top #(.FRAC_BITS(FRAC)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // nearest, ties away from zero
   function automatic longint round_div(longint num, longint den);
      if (num >= 0)
         return (num + den / 2) / den;
      return -((-num + den / 2) / den);
   endfunction

   function automatic longint tilt_step(longint cur, longint acc, longint aoff,
                                        longint gyr, longint goff,
                                        longint k1, longint k2);
      longint one, a, rate, num, nxt, lim;
      one  = longint'(1) << FRAC;
      a    = round_div((acc - aoff) * acc_scale * one, 65536);
      rate = round_div((gyr - goff) * 10 * one, 164);
      // k1 in thousandths, k2 in ten-thousandths
      num  = ((a - cur) * k1 + rate * 1000) * k2;
      nxt  = cur + round_div(num, 10000000);
      lim  = 360 * one;
      if (nxt > lim)
         nxt = lim;
      if (nxt < -lim)
         nxt = -lim;
      return nxt;
   endfunction

   function automatic tilt_word_t filter_sample(sample_t s);
      tilt_word_t r;
      longint     tc;
      tilt[0] = tilt_step(tilt[0], longint'($signed(s.accel_x)), acc_off[0],
                          longint'($signed(s.gyro_x)), gyro_off[0],
                          longint'(COEF_X.k1), longint'(COEF_X.k2));
      tilt[1] = tilt_step(tilt[1], longint'($signed(s.accel_y)), acc_off[1],
                          longint'($signed(s.gyro_y)), gyro_off[1],
                          longint'(COEF_YZ.k1), longint'(COEF_YZ.k2));
      tilt[2] = tilt_step(tilt[2], longint'($signed(s.accel_z)), acc_off[2],
                          longint'($signed(s.gyro_z)), gyro_off[2],
                          longint'(COEF_YZ.k1), longint'(COEF_YZ.k2));
      tc = round_div(longint'($signed(s.temp_raw)) * 5, 17) + 3625;
      r            = '0;
      r.angle_x    = tilt[0][ANGLE_W-1:0];
      r.angle_y    = tilt[1][ANGLE_W-1:0];
      r.angle_z    = tilt[2][ANGLE_W-1:0];
      r.temp_centi = tc[TEMP_W-1:0];
      return r;
   endfunction

   task automatic note_error(string msg);
      errors++;
      if (errors <= 10)
         $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   task automatic check_field(string name, logic [ANGLE_W-1:0] want,
                              logic [ANGLE_W-1:0] got);
      if (want !== got)
         note_error($sformatf("%s expected 0x%0h got 0x%0h (word %0d)",
                              name, want, got, n_checked));
   endtask

   // sender: one word held on req until taken
   always @(posedge clock) begin
      logic busy;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         busy = req_tvalid;
         if (req_tvalid && req_tready) begin
            tilt_due_q.push_back(filter_sample(sample_t'(req_tdata)));
            n_sent++;
            busy = 1'b0;
         end
         if (!busy) begin
            if (sample_q.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
               req_tdata  <= sample_q.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: random back-pressure, compare each word with the oldest prediction
   always @(posedge clock) begin
      tilt_word_t got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = tilt_word_t'(rsp_tdata);
            if (tilt_due_q.size() == 0) begin
               note_error($sformatf("unexpected word 0x%0h", rsp_tdata));
            end else begin
               want = tilt_due_q.pop_front();
               check_field("angle_x", want.angle_x, got.angle_x);
               check_field("angle_y", want.angle_y, got.angle_y);
               check_field("angle_z", want.angle_z, got.angle_z);
               check_field("temp_centi", ANGLE_W'(want.temp_centi),
                           ANGLE_W'(got.temp_centi));
            end
            n_checked++;
         end
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles == LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d words outstanding",
                  cycles, tilt_due_q.size());
         $display("imu_complementary_tilt_filter_top verification failed");
         $finish;
      end
   end

   task automatic write_csr(csr_reg_e idx, logic [15:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_ACC_OFF_X:  acc_off[0]  = longint'($signed(val));
         REG_ACC_OFF_Y:  acc_off[1]  = longint'($signed(val));
         REG_ACC_OFF_Z:  acc_off[2]  = longint'($signed(val));
         REG_GYRO_OFF_X: gyro_off[0] = longint'($signed(val));
         REG_GYRO_OFF_Y: gyro_off[1] = longint'($signed(val));
         REG_GYRO_OFF_Z: gyro_off[2] = longint'($signed(val));
         REG_ACC_SCALE:  acc_scale   = longint'(val);
         default: ;
      endcase
      n_csr++;
   endtask

   // wait until the sender is empty and every prediction is matched
   task automatic drain();
      forever begin
         @(posedge clock);
         if (sample_q.size() == 0 && !req_tvalid && tilt_due_q.size() == 0)
            break;
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic sample_t uniform(logic [15:0] acc, logic [15:0] gyr,
                                       logic [15:0] tmp);
      return '{temp_raw: tmp, gyro_z: gyr, gyro_y: gyr, gyro_x: gyr,
               accel_z: acc, accel_y: acc, accel_x: acc};
   endfunction

   function automatic logic [15:0] rand_field(logic [15:0] base);
      case ($urandom_range(9))
         0:       return 16'h8000;
         1:       return 16'h7fff;
         2:       return 16'h0000;
         3, 4, 5: return base + 16'($urandom_range(64)) - 16'd32;
         default: return 16'($urandom);
      endcase
   endfunction

   // runs of samples around a held pose so the tilts settle, with jumps and noise
   task automatic queue_random(int n);
      sample_t pose, s;
      pose = sample_t'({$urandom, $urandom, $urandom, $urandom});
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(15) == 0)
            pose = sample_t'({$urandom, $urandom, $urandom, $urandom});
         s.accel_x  = rand_field(pose.accel_x);
         s.accel_y  = rand_field(pose.accel_y);
         s.accel_z  = rand_field(pose.accel_z);
         s.gyro_x   = rand_field(pose.gyro_x);
         s.gyro_y   = rand_field(pose.gyro_y);
         s.gyro_z   = rand_field(pose.gyro_z);
         s.temp_raw = rand_field(pose.temp_raw);
         sample_q.push_back(s);
      end
   endtask

   task automatic random_offsets();
      write_csr(REG_ACC_OFF_X,  16'($urandom));
      write_csr(REG_ACC_OFF_Y,  16'($urandom));
      write_csr(REG_ACC_OFF_Z,  16'($urandom));
      write_csr(REG_GYRO_OFF_X, 16'($urandom));
      write_csr(REG_GYRO_OFF_Y, 16'($urandom));
      write_csr(REG_GYRO_OFF_Z, 16'($urandom));
   endtask

   initial begin
      sample_t s;
      acc_off   = '{0, 0, 0};
      gyro_off  = '{0, 0, 0};
      acc_scale = 720;
      tilt      = '{0, 0, 0};

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // reset settings: zero sample, then drive into both saturation rails
      sample_q.push_back(uniform(16'h0000, 16'h0000, 16'h0000));
      repeat (8) sample_q.push_back(uniform(16'h7fff, 16'h7fff, 16'h7fff));
      repeat (8) sample_q.push_back(uniform(16'h8000, 16'h8000, 16'h8000));
      sample_q.push_back(uniform(16'h7fff, 16'h8000, 16'hffff));
      sample_q.push_back(uniform(16'h8000, 16'h7fff, 16'h0001));
      s = uniform(16'h0001, 16'hffff, 16'h8000);
      s.accel_y = 16'h8000;
      s.gyro_z  = 16'h7fff;
      sample_q.push_back(s);
      drain();

      // full-range offsets and the largest scale; spare index must be ignored
      write_csr(REG_ACC_OFF_X,  16'h8000);
      write_csr(REG_ACC_OFF_Y,  16'h7fff);
      write_csr(REG_ACC_OFF_Z,  16'h8000);
      write_csr(REG_GYRO_OFF_X, 16'h7fff);
      write_csr(REG_GYRO_OFF_Y, 16'h8000);
      write_csr(REG_GYRO_OFF_Z, 16'h7fff);
      write_csr(REG_ACC_SCALE,  16'hffff);
      write_csr(REG_SPARE,      16'h1234);
      s = '{temp_raw: 16'h7fff, gyro_z: 16'h8000, gyro_y: 16'h7fff,
            gyro_x: 16'h8000, accel_z: 16'h7fff, accel_y: 16'h8000,
            accel_x: 16'h7fff};
      repeat (2) sample_q.push_back(s);
      s = '{temp_raw: 16'h8000, gyro_z: 16'h7fff, gyro_y: 16'h8000,
            gyro_x: 16'h7fff, accel_z: 16'h8000, accel_y: 16'h7fff,
            accel_x: 16'h8000};
      repeat (2) sample_q.push_back(s);
      queue_random(300);
      drain();

      // zero scale: accel angle reads zero; no stalls on either side
      write_csr(REG_ACC_SCALE, 16'h0000);
      random_offsets();
      steady <= 1'b1;
      queue_random(300);
      drain();
      steady <= 1'b0;

      // random settings, with a full drain halfway through
      write_csr(REG_ACC_SCALE, 16'($urandom));
      random_offsets();
      queue_random(200);
      drain();
      queue_random(200);
      drain();

      // back to the power-on settings
      write_csr(REG_ACC_SCALE,  16'd720);
      write_csr(REG_ACC_OFF_X,  16'h0000);
      write_csr(REG_ACC_OFF_Y,  16'h0000);
      write_csr(REG_ACC_OFF_Z,  16'h0000);
      write_csr(REG_GYRO_OFF_X, 16'h0000);
      write_csr(REG_GYRO_OFF_Y, 16'h0000);
      write_csr(REG_GYRO_OFF_Z, 16'h0000);
      queue_random(400);
      drain();

      if (tilt_due_q.size() != 0)
         note_error($sformatf("%0d words never arrived", tilt_due_q.size()));
      $display("%0d samples filtered, %0d words checked, %0d register writes",
               n_sent, n_checked, n_csr);
      $display("covered both tilt rails, zero and max scale, full-range offsets");
      if (errors == 0) begin
         $display("imu_complementary_tilt_filter_top verification clean");
      end else begin
         $display("%0d mismatches", errors);
         $display("imu_complementary_tilt_filter_top verification failed");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/ictf_pkg.sv
rtl/ictf_div.sv
rtl/ictf_lane.sv
rtl/ictf_merge.sv
rtl/imu_complementary_tilt_filter_top.sv
test/tb_imu_complementary_tilt_filter_top.sv
